// ===== hw/rtl/huffman_table_encoder_packer_defines.svh =====
// ----------------------------------------------------------------------------
// huffman_table_encoder_packer_defines
// Assertion macros shared by the encoder/packer RTL.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_TABLE_ENCODER_PACKER_DEFINES_SVH
`define HUFFMAN_TABLE_ENCODER_PACKER_DEFINES_SVH

// property held at every edge outside reset
`define HTEP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// trigger in one cycle implies outcome in the next
`define HTEP_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== hw/rtl/htep_pkg.sv =====
// ----------------------------------------------------------------------------
// htep_pkg
// Types and constants of the table-driven Huffman encoder and bit packer.
// ----------------------------------------------------------------------------
package htep_pkg;

    localparam int MAX_CODE_LEN_DEF = 32;

    localparam int SYM_W       = 8;
    localparam int TABLE_DEPTH = 256;
    localparam int IN_CODE_W   = 32;
    localparam int IN_LEN_W    = 6;
    localparam int OFFSET_W    = 30;
    localparam int TOTAL_W     = 32;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 40;

    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    localparam logic [OFFSET_W-1:0] BODY_START = 30'd4;

    typedef enum logic [2:0] {
        ST_RUN   = 3'b001,
        ST_FLUSH = 3'b010,
        ST_COUNT = 3'b100
    } state_t;

endpackage

// ===== hw/rtl/htep_ram.sv =====
// ----------------------------------------------------------------------------
// htep_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module htep_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/huffman_table_encoder_packer.sv =====
// ----------------------------------------------------------------------------
// huffman_table_encoder_packer
// Table-driven Huffman encoder with MSB-first byte packer and trailer count.
//
//   channel  dir  tuser      tdata (lsb up)                          tlast
//   s_       in   kind[1:0]  symbol, code_bits, code_length          -
//   m_       out  -          byte_offset, out_byte                   last
//
// Load and data items are taken one per cycle while the lookup stage can take
// them; the code table read is registered and hidden by the lookup stage. Each
// output byte passes the output register, so an item that completes k bytes
// holds input while its bytes are emitted; an end item yields five results.
// Reset clears valid flags for all 256 table entries at once, no sweep.
// Output stalls back up through the packer into the lookup stage.
// ----------------------------------------------------------------------------
`include "huffman_table_encoder_packer_defines.svh"

module huffman_table_encoder_packer #(
    parameter int MAX_CODE_LEN = htep_pkg::MAX_CODE_LEN_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [htep_pkg::S_TDATA_W-1:0] s_tdata,  // symbol, code_bits, code_length
    input  logic [1:0]                     s_tuser,  // kind
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [htep_pkg::M_TDATA_W-1:0] m_tdata,  // byte_offset, out_byte
    output logic                           m_tlast   // last
);

    localparam int CODE_W = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
    localparam int LEN_W  = $clog2(MAX_CODE_LEN + 1);
    localparam int ENT_W  = CODE_W + LEN_W;
    localparam int ACC_W  = MAX_CODE_LEN + 7;
    localparam int CNT_W  = $clog2(ACC_W + 1);
    localparam int OFF_W  = htep_pkg::OFFSET_W;
    localparam int TOT_W  = htep_pkg::TOTAL_W;

    // input unpack
    logic [htep_pkg::SYM_W-1:0]     in_sym;
    logic [htep_pkg::IN_CODE_W-1:0] in_code;
    logic [htep_pkg::IN_LEN_W-1:0]  in_len;
    logic                           s_fire;
    logic                           is_load;
    logic                           is_data;
    logic                           is_end;

    assign in_sym  = s_tdata[7:0];
    assign in_code = s_tdata[39:8];
    assign in_len  = s_tdata[45:40];
    assign s_fire  = s_tvalid && s_tready;
    assign is_load = (s_tuser == htep_pkg::KIND_LOAD);
    assign is_data = (s_tuser == htep_pkg::KIND_DATA);
    assign is_end  = (s_tuser == htep_pkg::KIND_END);

    // table write
    logic [htep_pkg::IN_LEN_W-1:0]  sat_len;
    logic [63:0]                    len_mask;
    logic [htep_pkg::IN_CODE_W-1:0] masked_code;
    logic [ENT_W-1:0]               wr_entry;
    logic [ENT_W-1:0]               rd_entry;

    assign sat_len = (in_len > htep_pkg::IN_LEN_W'(MAX_CODE_LEN)) ?
                     htep_pkg::IN_LEN_W'(MAX_CODE_LEN) : in_len;
    assign len_mask    = ~({64{1'b1}} << sat_len);
    assign masked_code = in_code & len_mask[31:0];
    assign wr_entry    = {sat_len[LEN_W-1:0], masked_code[CODE_W-1:0]};

    htep_ram #(
        .WIDTH(ENT_W),
        .DEPTH(htep_pkg::TABLE_DEPTH)
    ) u_table (
        .aclk   (aclk),
        .wr_en  (s_fire && is_load),
        .wr_addr(in_sym),
        .wr_data(wr_entry),
        .rd_en  (s_fire && is_data),
        .rd_addr(in_sym),
        .rd_data(rd_entry)
    );

    logic [htep_pkg::TABLE_DEPTH-1:0] valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (s_fire && is_load) begin
            valid_reg[in_sym] <= 1'b1;
        end
    end

    // lookup stage
    logic s2_valid_reg;
    logic s2_end_reg;
    logic s2_hit_reg;
    logic s2_consume;

    assign s_tready = !s2_valid_reg || s2_consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s_fire && (is_data || is_end)) begin
            s2_valid_reg <= 1'b1;
        end else if (s2_consume) begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s2_end_reg <= is_end;
            s2_hit_reg <= valid_reg[in_sym];
        end
    end

    logic [LEN_W-1:0]  len_eff;
    logic [CODE_W-1:0] bits_eff;
    logic [CNT_W-1:0]  len_ext;
    logic [ACC_W-1:0]  code_ext;

    assign len_eff  = s2_hit_reg ? rd_entry[ENT_W-1:CODE_W] : '0;
    assign bits_eff = s2_hit_reg ? rd_entry[CODE_W-1:0] : '0;
    assign len_ext  = CNT_W'(len_eff);
    assign code_ext = ACC_W'(bits_eff);

    // packer
    htep_pkg::state_t  state_reg, state_next;
    logic [ACC_W-1:0]  word_reg, word_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [TOT_W-1:0]  total_reg, total_next;
    logic [OFF_W-1:0]  offset_reg, offset_next;
    logic [1:0]        idx_reg, idx_next;

    logic              out_free;
    logic              have_byte;
    logic              emit;
    logic              body_emit;
    logic [ACC_W-1:0]  eff_word;
    logic [CNT_W-1:0]  eff_cnt;
    logic [CNT_W-1:0]  shamt;
    logic [ACC_W-1:0]  aligned;
    logic [OFF_W-1:0]  emit_offset;
    logic [7:0]        emit_byte;
    logic              emit_last;

    logic              m_valid_reg;
    logic [OFF_W-1:0]  m_offset_reg;
    logic [7:0]        m_byte_reg;
    logic              m_last_reg;

    assign out_free  = !m_valid_reg || m_tready;
    assign have_byte = ((state_reg == htep_pkg::ST_RUN) && (cnt_reg >= CNT_W'(8))) ||
                       (state_reg == htep_pkg::ST_FLUSH) || (state_reg == htep_pkg::ST_COUNT);
    assign emit      = have_byte && out_free;
    assign body_emit = emit && (state_reg == htep_pkg::ST_RUN);
    assign eff_word  = body_emit ? (word_reg << 8) : word_reg;
    assign eff_cnt   = body_emit ? (cnt_reg - CNT_W'(8)) : cnt_reg;
    assign s2_consume = s2_valid_reg && (state_reg == htep_pkg::ST_RUN) &&
                        (eff_cnt < CNT_W'(8));
    assign shamt     = CNT_W'(ACC_W) - len_ext - eff_cnt;
    assign aligned   = code_ext << shamt;

    always_comb begin
        emit_offset = offset_reg;
        emit_byte   = word_reg[ACC_W-1 -: 8];
        emit_last   = 1'b0;
        if (state_reg == htep_pkg::ST_COUNT) begin
            emit_offset = OFF_W'(idx_reg);
            emit_last   = (idx_reg == 2'd3);
            unique case (idx_reg)
                2'd0: emit_byte = total_reg[31:24];
                2'd1: emit_byte = total_reg[23:16];
                2'd2: emit_byte = total_reg[15:8];
                2'd3: emit_byte = total_reg[7:0];
            endcase
        end
    end

    always_comb begin
        state_next  = state_reg;
        word_next   = word_reg;
        cnt_next    = cnt_reg;
        total_next  = total_reg;
        offset_next = offset_reg;
        idx_next    = idx_reg;
        unique case (state_reg)
            htep_pkg::ST_RUN: begin
                word_next = eff_word;
                cnt_next  = eff_cnt;
                if (body_emit) begin
                    offset_next = offset_reg + OFF_W'(1);
                end
                if (s2_consume) begin
                    if (s2_end_reg) begin
                        state_next = htep_pkg::ST_FLUSH;
                    end else begin
                        word_next  = eff_word | aligned;
                        cnt_next   = eff_cnt + len_ext;
                        total_next = total_reg + TOT_W'(len_eff);
                    end
                end
            end
            htep_pkg::ST_FLUSH: begin
                if (emit) begin
                    state_next  = htep_pkg::ST_COUNT;
                    idx_next    = 2'd0;
                    word_next   = '0;
                    cnt_next    = '0;
                    offset_next = htep_pkg::BODY_START;
                end
            end
            htep_pkg::ST_COUNT: begin
                if (emit) begin
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == 2'd3) begin
                        state_next = htep_pkg::ST_RUN;
                        total_next = '0;
                    end
                end
            end
            default: begin
                state_next = htep_pkg::ST_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= htep_pkg::ST_RUN;
            word_reg   <= '0;
            cnt_reg    <= '0;
            total_reg  <= '0;
            offset_reg <= htep_pkg::BODY_START;
            idx_reg    <= '0;
        end else begin
            state_reg  <= state_next;
            word_reg   <= word_next;
            cnt_reg    <= cnt_next;
            total_reg  <= total_next;
            offset_reg <= offset_next;
            idx_reg    <= idx_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_offset_reg <= emit_offset;
            m_byte_reg   <= emit_byte;
            m_last_reg   <= emit_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_byte_reg, m_offset_reg};
    assign m_tlast  = m_last_reg;

    // checks
    `HTEP_ASSERT(a_cnt_below_byte, (state_reg != htep_pkg::ST_RUN) |-> (cnt_reg < CNT_W'(8)), "bits of a full byte left in packer during end run")
    `HTEP_ASSERT_NEXT(a_end_clears, emit && (state_reg == htep_pkg::ST_COUNT) && (idx_reg == 2'd3), (state_reg == htep_pkg::ST_RUN) && (total_reg == '0) && (offset_reg == htep_pkg::BODY_START), "packer not cleared after end run")
    `HTEP_ASSERT_NEXT(a_offset_step, body_emit, offset_reg == $past(offset_reg) + OFF_W'(1), "body offset did not advance by one")

endmodule
